@@ design/ffdc8_pkg.sv @@
// package: frame constants and crc-8 helpers for the fixed-frame deframer
`timescale 1ns / 1ps
`default_nettype none
package ffdc8_pkg;

	localparam int FRAME_LEN = 24;
	localparam int CRC_SPAN  = 22;
	localparam int CRC_POS   = 22;
	localparam int CNT_W     = $clog2(FRAME_LEN + 1);

	localparam logic [7:0] HEAD_BYTE = 8'hA5;
	localparam logic [7:0] ID_BYTE   = 8'h01;
	localparam logic [7:0] LEN_BYTE  = 8'h12;
	localparam logic [7:0] TAIL_BYTE = 8'h5A;
	localparam logic [7:0] CRC_POLY  = 8'h07;
	localparam int         FLAG_BIT  = 7;

	localparam logic [CNT_W-1:0] FRESH_FULL = CNT_W'(FRAME_LEN);

	typedef logic [7:0] byte_t;

	// contribution of one set bit (byte pos, bit bit_idx) to the crc over the span;
	// only ever called with constant arguments, so it folds to a constant column
	function automatic byte_t crc_col(input int pos, input int bit_idx);
		byte_t c;
		logic  top;
		c = '0;
		for (int k = 0; k < CRC_SPAN; k++) begin
			if (k == pos) begin
				c = c ^ byte_t'(1 << bit_idx);
			end
			for (int b = 0; b < 8; b++) begin
				top = c[7];
				c = {c[6:0], 1'b0};
				if (top) begin
					c = c ^ CRC_POLY;
				end
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ design/fixed_frame_deframer_crc8_unit.sv @@
// top level: 24-byte frame sync with crc-8 check, one byte per cycle unless stalled
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | rx_byte
//  out     | out_valid / out_ready| yaw_bits, pitch_bits, mode_byte,
//          |                      | air_support_flag
//
// one byte per cycle while in_ready is high: the byte shifts into the window
// register, the header, tail and crc xor tree then check that window, and a
// hit is loaded into the output register when the output advances.
// reset clears the fresh count and all valid flags.
// a stalled output blocks in_ready only while an unchecked byte is also pending.
`timescale 1ns / 1ps
`default_nettype none
module fixed_frame_deframer_crc8_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ffdc8_pkg::byte_t     rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [31:0]               yaw_bits,
	output logic [31:0]               pitch_bits,
	output logic [7:0]                mode_byte,
	output logic                      air_support_flag
);
	import ffdc8_pkg::*;

	byte_t            window_s1 [FRAME_LEN];
	logic             valid_s1;
	logic [CNT_W-1:0] fresh_q;
	logic             out_valid_q;
	logic             advance;
	logic             in_take;
	logic             match;
	logic             hit;
	byte_t            crc;
	logic [CNT_W-1:0] fresh_base;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign in_take  = in_valid && in_ready;

	// crc is linear: xor of constant columns for every set bit of the span
	always_comb begin
		crc = '0;
		for (int i = 0; i < CRC_SPAN; i++) begin
			for (int b = 0; b < 8; b++) begin
				if (window_s1[i][b]) begin
					crc = crc ^ crc_col(i, b);
				end
			end
		end
	end

	assign match = (fresh_q == FRESH_FULL) &&
		(window_s1[0] == HEAD_BYTE) && (window_s1[1] == ID_BYTE) &&
		(window_s1[2] == LEN_BYTE) && (window_s1[FRAME_LEN-1] == TAIL_BYTE) &&
		(crc == window_s1[CRC_POS]);
	assign hit = advance && valid_s1 && match;

	assign fresh_base = hit ? '0 : fresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fresh_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (in_take) begin
				fresh_q <= (fresh_base == FRESH_FULL) ? FRESH_FULL : fresh_base + CNT_W'(1);
			end else begin
				fresh_q <= fresh_base;
			end
			if (advance) begin
				out_valid_q <= hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			for (int i = 0; i < FRAME_LEN - 1; i++) begin
				window_s1[i] <= window_s1[i+1];
			end
			window_s1[FRAME_LEN-1] <= rx_byte;
		end
		if (hit) begin
			yaw_bits         <= {window_s1[7], window_s1[6], window_s1[5], window_s1[4]};
			pitch_bits       <= {window_s1[11], window_s1[10], window_s1[9], window_s1[8]};
			mode_byte        <= window_s1[21];
			air_support_flag <= window_s1[20][FLAG_BIT];
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ design/ffdc8_checker.sv @@
// checker: port-level properties of the deframer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ffdc8_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] yaw_bits,
	input wire logic [31:0] pitch_bits
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(yaw_bits) && $stable(pitch_bits))
		else $error("result changed while stalled");

	// input only backs up behind a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked without a stalled result");

	// a fresh result traces back to the accepted byte that completed it
	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input transaction");

endmodule

bind fixed_frame_deframer_crc8_unit ffdc8_checker u_ffdc8_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.yaw_bits   (yaw_bits),
	.pitch_bits (pitch_bits)
);
`default_nettype wire
